### hdl/dq_pkg.sv
`default_nettype none
package dq_pkg;

   // field widths
   localparam int ModeW   = 3;
   localparam int ValueW  = 32;
   localparam int StatusW = 2;

   // operation codes carried on req_tuser
   localparam logic [ModeW-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [ModeW-1:0] MODE_PUSH_REAR  = 3'd1;
   localparam logic [ModeW-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [ModeW-1:0] MODE_POP_REAR   = 3'd3;
   localparam logic [ModeW-1:0] MODE_DUMP       = 3'd4;

   // result status codes carried on rsp_tuser
   localparam logic [StatusW-1:0] ST_OK    = 2'd0;
   localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
   localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic               push_front;
      logic               push_rear;
      logic               pop_front;
      logic               pop_rear;
      logic               dump_start;
      logic               dump_step;
      logic               out_load;
      logic               out_from_mem;
      logic               out_last;
      logic [StatusW-1:0] out_status;
   } dq_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic full;
      logic empty;
      logic dump_last;
      logic out_free;
   } dq_stat_type;

endpackage
`default_nettype wire

### hdl/dq_ctrl.sv
`default_nettype none
module dq_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   input  wire logic [dq_pkg::ModeW-1:0] req_mode,
   input  dq_pkg::dq_stat_type          stat,
   output logic                         req_tready,
   output dq_pkg::dq_cmd_type           cmd
);
   import dq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP_RD,
      S_DUMP_RD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // next state and command decode
   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      cmd.out_last     = 1'b1;
      cmd.out_status   = ST_OK;
      req_tready       = 1'b0;
      accept           = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = stat.out_free;
            accept     = req_tvalid && stat.out_free;
            if (accept) begin
               unique case (req_mode) inside
                  MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                     cmd.out_load = 1'b1;
                     if (stat.full) begin
                        cmd.out_status = ST_FULL;
                     end else begin
                        cmd.push_front = (req_mode == MODE_PUSH_FRONT);
                        cmd.push_rear  = (req_mode == MODE_PUSH_REAR);
                     end
                  end
                  MODE_POP_FRONT, MODE_POP_REAR: begin
                     if (stat.empty) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_EMPTY;
                     end else begin
                        cmd.pop_front = (req_mode == MODE_POP_FRONT);
                        cmd.pop_rear  = (req_mode == MODE_POP_REAR);
                        state_in      = S_POP_RD;
                     end
                  end
                  MODE_DUMP: begin
                     if (stat.empty) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_EMPTY;
                     end else begin
                        cmd.dump_start = 1'b1;
                        state_in       = S_DUMP_RD;
                     end
                  end
                  default: begin
                     // unused codes are dropped without a result
                  end
               endcase
            end
         end
         S_POP_RD: begin
            if (stat.out_free) begin
               cmd.out_load     = 1'b1;
               cmd.out_from_mem = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_DUMP_RD: begin
            if (stat.out_free) begin
               cmd.out_load     = 1'b1;
               cmd.out_from_mem = 1'b1;
               cmd.out_last     = stat.dump_last;
               if (stat.dump_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.dump_step = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### hdl/dq_datapath.sv
`default_nettype none
module dq_datapath #(
   parameter int DEPTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  dq_pkg::dq_cmd_type                     cmd,
   input  wire logic signed [dq_pkg::ValueW-1:0]  req_value,
   input  wire logic                              rsp_tready,
   output dq_pkg::dq_stat_type                    stat,
   output logic                                   rsp_valid,
   output logic signed [dq_pkg::ValueW-1:0]       rsp_value,
   output logic [dq_pkg::StatusW-1:0]             rsp_status,
   output logic                                   rsp_last
);
   import dq_pkg::*;

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   // ring position front + offset, offset below DEPTH
   function automatic logic [PtrW-1:0] slot_at(input logic [PtrW-1:0] base,
                                               input logic [CntW-1:0] offset);
      logic [PtrW:0] sum;
      sum = {1'b0, base} + (PtrW+1)'(offset);
      if (sum >= (PtrW+1)'(DEPTH)) begin
         sum = sum - (PtrW+1)'(DEPTH);
      end
      return sum[PtrW-1:0];
   endfunction

   function automatic logic [PtrW-1:0] wrap_next(input logic [PtrW-1:0] p);
      return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
   endfunction

   function automatic logic [PtrW-1:0] wrap_prev(input logic [PtrW-1:0] p);
      return (p == '0) ? PtrW'(DEPTH - 1) : p - PtrW'(1);
   endfunction

   logic [ValueW-1:0]        mem_ff [DEPTH];
   logic [ValueW-1:0]        rd_data_ff;
   logic [PtrW-1:0]          front_ff;
   logic [CntW-1:0]          count_ff;
   logic [PtrW-1:0]          dptr_ff;
   logic [CntW-1:0]          remain_ff;
   logic                     rsp_valid_ff;
   logic [ValueW-1:0]        rsp_value_ff;
   logic [StatusW-1:0]       rsp_status_ff;
   logic                     rsp_last_ff;

   logic [PtrW-1:0]          prev_front;
   logic [PtrW-1:0]          next_front;
   logic [PtrW-1:0]          rear_slot;
   logic [PtrW-1:0]          last_slot;
   logic                     wr_en;
   logic [PtrW-1:0]          wr_addr;
   logic                     rd_en;
   logic [PtrW-1:0]          rd_addr;

   // address generation
   always_comb begin
      prev_front = wrap_prev(front_ff);
      next_front = wrap_next(front_ff);
      rear_slot  = slot_at(front_ff, count_ff);
      last_slot  = slot_at(front_ff, count_ff - CntW'(1));
      wr_en      = cmd.push_front || cmd.push_rear;
      wr_addr    = cmd.push_front ? prev_front : rear_slot;
      rd_en      = cmd.pop_front || cmd.pop_rear || cmd.dump_start || cmd.dump_step;
      if (cmd.pop_rear) begin
         rd_addr = last_slot;
      end else if (cmd.dump_step) begin
         rd_addr = dptr_ff;
      end else begin
         rd_addr = front_ff;
      end
   end

   // entry store, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // front position and element count
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.push_front) begin
            front_ff <= prev_front;
         end else if (cmd.pop_front) begin
            front_ff <= next_front;
         end
         if (cmd.push_front || cmd.push_rear) begin
            count_ff <= count_ff + CntW'(1);
         end else if (cmd.pop_front || cmd.pop_rear) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

   // dump walk pointer and remaining entries
   always_ff @(posedge clock) begin
      if (cmd.dump_start) begin
         dptr_ff   <= next_front;
         remain_ff <= count_ff;
      end else if (cmd.dump_step) begin
         dptr_ff   <= wrap_next(dptr_ff);
         remain_ff <= remain_ff - CntW'(1);
      end
   end

   // result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_value_ff  <= cmd.out_from_mem ? rd_data_ff : '0;
         rsp_status_ff <= cmd.out_status;
         rsp_last_ff   <= cmd.out_last;
      end
   end

   always_comb begin
      stat.full      = (count_ff == CntW'(DEPTH));
      stat.empty     = (count_ff == '0);
      stat.dump_last = (remain_ff == CntW'(1));
      stat.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
`default_nettype wire

### hdl/double_ended_queue.sv
`default_nettype none
// Double-ended queue of signed 32-bit values held in a ring store of DEPTH
// entries. req_tuser selects push front, push rear, pop front, pop rear or
// dump; every push or pop returns one result with a status (ok, empty, or
// full with the push refused), and a dump returns every entry from front to
// rear with tlast on the final one, or a single empty result. Pushes and
// refused operations can follow back to back while the receiver takes
// every result at once. A pop or a dump holds off further input while the
// entry store is read, since the store has a registered read port. A
// result that waits in the output register holds off the next item; that
// item is taken in the cycle in which the waiting result transfers. Unused
// codes are taken and dropped without a result.
module double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic [7:0]  req_tuser,   // [2:0] mode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] result_value
   output logic [7:0]       rsp_tuser,   // [1:0] status
   output logic             rsp_tlast
);
   import dq_pkg::*;

   dq_cmd_type               cmd;
   dq_stat_type              stat;
   logic signed [ValueW-1:0] rsp_value;
   logic [StatusW-1:0]       rsp_status;
   logic [ModeW-1:0]         req_mode;

   assign req_mode = req_tuser[ModeW-1:0];

   dq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_mode),
      .stat       (stat),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   dq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_value  (req_tdata),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .rsp_valid  (rsp_tvalid),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = rsp_value;
   assign rsp_tuser = {{(8-StatusW){1'b0}}, rsp_status};

   // a push transfer is answered in the next cycle with a final result
   a_push_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready &&
       (req_mode == MODE_PUSH_FRONT || req_mode == MODE_PUSH_REAR))
      |=> (rsp_tvalid && rsp_tlast))
      else $error("push transfer gave no final result");

   // empty or full results are final and carry zero
   a_err_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[StatusW-1:0] != ST_OK)
      |-> (rsp_tlast && rsp_tdata == '0))
      else $error("error result not final or not zero");

   // a pop of a non-empty queue blocks input while the store is read
   a_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !stat.empty &&
       (req_mode == MODE_POP_FRONT || req_mode == MODE_POP_REAR))
      |=> !req_tready)
      else $error("input taken during pop read");

   // the queue can never be both full and empty
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      !(stat.full && stat.empty))
      else $error("queue both full and empty");

endmodule
`default_nettype wire

### bench/dq_checker.sv
`timescale 1ns / 1ps
// Deque checker: follows both stream channels, keeps its own copy of the
// ring store, and compares every result transfer with the oldest prediction.
module dq_checker
   import dq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [31:0]       req_tdata,   // [31:0] value
   input  logic [7:0]        req_tuser,   // [2:0] mode
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [31:0]       rsp_tdata,   // [31:0] result_value
   input  logic [7:0]        rsp_tuser,   // [1:0] status
   input  logic              rsp_tlast,
   output int unsigned       pending_results,
   output int unsigned       fail_count
);

   typedef struct packed {
      logic signed [ValueW-1:0] value;
      logic [StatusW-1:0]       status;
      logic                     last;
   } dq_result_type;

   // shadow of the ring store
   logic [ValueW-1:0] ring_model [DEPTH];
   int unsigned       head_slot;
   int unsigned       fill_level;
   dq_result_type     expected_results [$];
   int unsigned       errors;

   initial begin
      pending_results = 0;
      fail_count      = 0;
      errors          = 0;
      head_slot       = 0;
      fill_level      = 0;
   end

   function automatic dq_result_type make_result(input logic [ValueW-1:0] value,
                                                 input logic [StatusW-1:0] status,
                                                 input logic last);
      dq_result_type r;
      r.value  = value;
      r.status = status;
      r.last   = last;
      return r;
   endfunction

   // apply one accepted operation and queue the results it causes
   task automatic predict_op(input logic [ModeW-1:0] mode, input logic [ValueW-1:0] value);
      int unsigned i;
      case (mode) inside
         MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
            if (fill_level == DEPTH) begin
               expected_results.push_back(make_result('0, ST_FULL, 1'b1));
            end else begin
               if (mode == MODE_PUSH_FRONT) begin
                  head_slot = (head_slot + DEPTH - 1) % DEPTH;
                  ring_model[head_slot] = value;
               end else begin
                  ring_model[(head_slot + fill_level) % DEPTH] = value;
               end
               fill_level++;
               expected_results.push_back(make_result('0, ST_OK, 1'b1));
            end
         end
         MODE_POP_FRONT: begin
            if (fill_level == 0) begin
               expected_results.push_back(make_result('0, ST_EMPTY, 1'b1));
            end else begin
               expected_results.push_back(make_result(ring_model[head_slot], ST_OK, 1'b1));
               head_slot = (head_slot + 1) % DEPTH;
               fill_level--;
            end
         end
         MODE_POP_REAR: begin
            if (fill_level == 0) begin
               expected_results.push_back(make_result('0, ST_EMPTY, 1'b1));
            end else begin
               expected_results.push_back(
                  make_result(ring_model[(head_slot + fill_level - 1) % DEPTH], ST_OK, 1'b1));
               fill_level--;
            end
         end
         MODE_DUMP: begin
            if (fill_level == 0) begin
               expected_results.push_back(make_result('0, ST_EMPTY, 1'b1));
            end else begin
               for (i = 0; i < fill_level; i++) begin
                  expected_results.push_back(
                     make_result(ring_model[(head_slot + i) % DEPTH], ST_OK,
                                 i + 1 == fill_level));
               end
            end
         end
         default: ; // unused codes are dropped
      endcase
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      dq_result_type want;
      if (reset) begin
         head_slot  = 0;
         fill_level = 0;
         expected_results.delete();
      end else begin
         // result transfer against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result: expected none, actual value %0h status %0d last %0b",
                        $time, rsp_tdata, rsp_tuser[StatusW-1:0], rsp_tlast);
            end else begin
               want = expected_results.pop_front();
               compare_field("value", want.value, rsp_tdata);
               compare_field("status", 32'(want.status), 32'(rsp_tuser[StatusW-1:0]));
               compare_field("last", 32'(want.last), 32'(rsp_tlast));
            end
         end
         // operation transfer
         if (req_tvalid && req_tready)
            predict_op(req_tuser[ModeW-1:0], req_tdata);
      end
      pending_results <= expected_results.size();
      fail_count      <= errors;
   end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import dq_pkg::*;

   localparam int DEPTH             = 16;
   localparam int TARGET_OPS        = 430;
   localparam int RESET_CYCLES      = 6;
   localparam int LONG_STALL_CYCLES = 80;
   localparam int WATCHDOG_LIMIT    = 5000;
   localparam int SETTLE_CYCLES     = 20;

   // phase flavors of the random part
   localparam int PHASE_FILL  = 0;
   localparam int PHASE_DRAIN = 1;
   localparam int PHASE_MIXED = 2;

   // mode codes with no operation behind them
   localparam logic [ModeW-1:0] MODE_UNUSED_A = 3'd5;
   localparam logic [ModeW-1:0] MODE_UNUSED_B = 3'd6;
   localparam logic [ModeW-1:0] MODE_UNUSED_C = 3'd7;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] value
   logic [7:0]  req_tuser  = '0;   // [2:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] result_value
   logic [7:0]  rsp_tuser;         // [1:0] status
   logic        rsp_tlast;

   int unsigned pending_results;
   int unsigned fail_count;
   int unsigned ops_sent      = 0;
   int unsigned idle_cycles   = 0;
   int unsigned hold_left     = 0;
   bit          no_idle       = 1'b0;
   bit          stall_request = 1'b0;

   always #1 clock = ~clock;

   double_ended_queue #(.DEPTH(DEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   dq_checker #(.DEPTH(DEPTH)) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .pending_results (pending_results),
      .fail_count      (fail_count)
   );

   // mostly short idle stretches, now and then a long one
   function automatic int unsigned idle_len();
      if ($urandom_range(0, 9) < 9)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [ModeW-1:0] pick_mode(input int phase);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 3)
         return ModeW'($urandom_range(MODE_UNUSED_A, MODE_UNUSED_C));
      case (phase)
         PHASE_FILL: begin
            if (r < 78) return ($urandom_range(0, 1) != 0) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
            if (r < 90) return ($urandom_range(0, 1) != 0) ? MODE_POP_FRONT : MODE_POP_REAR;
            return MODE_DUMP;
         end
         PHASE_DRAIN: begin
            if (r < 78) return ($urandom_range(0, 1) != 0) ? MODE_POP_FRONT : MODE_POP_REAR;
            if (r < 92) return ($urandom_range(0, 1) != 0) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
            return MODE_DUMP;
         end
         default: return ModeW'($urandom_range(MODE_PUSH_FRONT, MODE_DUMP));
      endcase
   endfunction

   // offer one operation and hold it until the transfer
   task automatic send_op(input logic [ModeW-1:0] mode, input logic [31:0] value);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= {{(8-ModeW){1'b0}}, mode};
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (mode <= MODE_DUMP)
         ops_sent++;
      gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender pauses until every predicted result has been seen
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            hold_left = LONG_STALL_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0)
               hold_left = idle_len();
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[double_ended_queue] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int phase;
      int unsigned phase_len;
      int unsigned i;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes at both ends, every operation, empty cases, unused codes
      send_op(MODE_PUSH_FRONT, 32'h7fff_ffff);
      send_op(MODE_PUSH_REAR,  32'h8000_0000);
      send_op(MODE_PUSH_FRONT, 32'h0000_0000);
      send_op(MODE_PUSH_REAR,  32'hffff_ffff);
      send_op(MODE_DUMP,       32'h5a5a_a5a5);
      send_op(MODE_POP_FRONT,  32'hffff_ffff);
      send_op(MODE_POP_REAR,   32'h0000_0000);
      send_op(MODE_UNUSED_A,   32'h1234_5678);
      send_op(MODE_POP_FRONT,  32'h0);
      send_op(MODE_POP_REAR,   32'h0);
      send_op(MODE_POP_FRONT,  32'h0);
      send_op(MODE_POP_REAR,   32'h0);
      send_op(MODE_DUMP,       32'h0);
      send_op(MODE_UNUSED_B,   32'hffff_ffff);
      send_op(MODE_UNUSED_C,   32'h0);

      // fill past full while the receiver holds off, then dump everything
      stall_request = 1'b1;
      for (i = 0; i < DEPTH + 4; i++)
         send_op(($urandom_range(0, 1) != 0) ? MODE_PUSH_FRONT : MODE_PUSH_REAR, pick_value());
      send_op(MODE_DUMP, $urandom);
      wait_drained();

      // random phases biased toward filling, draining or neither
      while (ops_sent < TARGET_OPS) begin
         phase     = $urandom_range(PHASE_FILL, PHASE_MIXED);
         phase_len = $urandom_range(10, 40);
         no_idle   = ($urandom_range(0, 3) == 0);
         for (i = 0; i < phase_len; i++)
            send_op(pick_mode(phase), pick_value());
         if ($urandom_range(0, 4) == 0)
            wait_drained();
      end
      no_idle = 1'b0;

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("[double_ended_queue] OK");
      else
         $display("[double_ended_queue] ERROR");
      $finish;
   end

endmodule
